[rtl/ucep_pkg.sv]
// Package for the USB control endpoint stage sequencer.
// Holds the beat payload structs, event, stage and action codes, and a shared helper.
// No dependencies.
package ucep_pkg;

    localparam int DataW = 16;

    // Event codes carried in the cmd field
    localparam logic [1:0] CMD_SETUP    = 2'd0;
    localparam logic [1:0] CMD_IN_DONE  = 2'd1;
    localparam logic [1:0] CMD_OUT_DONE = 2'd2;

    // Endpoint actions
    localparam logic [1:0] ACT_READ       = 2'd0;
    localparam logic [1:0] ACT_WRITE      = 2'd1;
    localparam logic [1:0] ACT_STALL_EP   = 2'd2;
    localparam logic [1:0] ACT_STALL_BOTH = 2'd3;

    // Configuration register indexes
    localparam logic REG_PACKET_SIZE_LOG2 = 1'b0;

    localparam logic [2:0] PacketLog2Reset = 3'd6;

    typedef enum logic [2:0] {
        ST_REQUEST     = 3'd0,
        ST_DATA_IN     = 3'd1,
        ST_DATA_IN_ZLP = 3'd2,
        ST_DATA_OUT    = 3'd3,
        ST_STATUS_IN   = 3'd4,
        ST_STATUS_OUT  = 3'd5
    } t_stage;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [7:0]       request_type;
        logic [DataW-1:0] request_length;
        logic [DataW-1:0] request_index;
        logic             handled;
        logic [DataW-1:0] response_size;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       action;
        logic [DataW-1:0] length;
        logic             with_data;
        logic [DataW-1:0] stall_endpoint;
        logic             request_done;
        logic             sequence_error;
        logic [2:0]       stage;
        logic             last;
    } t_out_item;

    // Decision of the sequencer for the item held in the input register
    typedef struct packed {
        t_out_item first;
        t_out_item second;
        logic      any;     // the item causes at least one result
        logic      two;     // the item causes two results
    } t_seq_out;

    // Build a result with stage and last left clear
    function automatic t_out_item make_result(
        input logic [1:0]       action,
        input logic [DataW-1:0] length,
        input logic             with_data,
        input logic [DataW-1:0] stall_ep,
        input logic             done,
        input logic             err
    );
        t_out_item r;
        r.action         = action;
        r.length         = length;
        r.with_data      = with_data;
        r.stall_endpoint = stall_ep;
        r.request_done   = done;
        r.sequence_error = err;
        r.stage          = 3'd0;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage

[rtl/ucep_cfg.sv]
// APB-style configuration register for the control endpoint sequencer.
// Holds packet_size_log2. Depends on ucep_pkg.
module ucep_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [2:0]  o_packet_size_log2
);
    import ucep_pkg::*;

    logic [2:0] r_packet_size_log2;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_PACKET_SIZE_LOG2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_size_log2 <= PacketLog2Reset;
        end else if (wr_en) begin
            r_packet_size_log2 <= pwdata[2:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PACKET_SIZE_LOG2: prdata = {29'd0, r_packet_size_log2};
            default:              prdata = 32'd0;
        endcase
    end

    assign o_packet_size_log2 = r_packet_size_log2;

endmodule

[rtl/ucep_seq.sv]
// Stage register and result decision of the control endpoint sequencer.
// Depends on ucep_pkg.
module ucep_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ucep_pkg::t_in_item  i_item,
    input  logic                i_commit,
    input  logic [2:0]          i_packet_size_log2,
    output ucep_pkg::t_seq_out  o_seq
);
    import ucep_pkg::*;

    t_stage           r_stage;
    t_stage           n_stage;
    logic [2:0]       psz_log2;
    logic [DataW-1:0] psz;
    logic [DataW-1:0] psz_mask;
    logic [DataW-1:0] size;
    logic             short_whole;
    t_out_item        first;
    t_out_item        second;

    // Clamp packet size to 8..64 bytes
    always_comb begin
        if (i_packet_size_log2 < 3'd3) begin
            psz_log2 = 3'd3;
        end else if (i_packet_size_log2 > 3'd6) begin
            psz_log2 = 3'd6;
        end else begin
            psz_log2 = i_packet_size_log2;
        end
    end

    assign psz      = DataW'(1) << psz_log2;
    assign psz_mask = psz - DataW'(1);
    assign size     = (i_item.response_size > i_item.request_length) ?
                      i_item.request_length : i_item.response_size;
    assign short_whole = (size < i_item.request_length) && ((size & psz_mask) == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_REQUEST;
        end else if (i_commit) begin
            r_stage <= n_stage;
        end
    end

    // Next stage
    always_comb begin
        n_stage = r_stage;
        case (i_item.cmd)
            CMD_SETUP: begin
                if (!i_item.handled) begin
                    n_stage = ST_REQUEST;
                end else if (!i_item.request_type[7]) begin
                    n_stage = (size != '0) ? ST_DATA_OUT : ST_STATUS_IN;
                end else if (short_whole) begin
                    n_stage = (size != '0) ? ST_DATA_IN_ZLP : ST_DATA_IN;
                end else begin
                    n_stage = (size != '0) ? ST_DATA_IN : ST_STATUS_OUT;
                end
            end
            CMD_IN_DONE: begin
                unique case (r_stage)
                    ST_DATA_IN_ZLP: n_stage = ST_DATA_IN;
                    ST_DATA_IN:     n_stage = ST_STATUS_OUT;
                    default:        n_stage = ST_REQUEST;
                endcase
            end
            CMD_OUT_DONE: begin
                unique case (r_stage)
                    ST_DATA_OUT: n_stage = ST_STATUS_IN;
                    default:     n_stage = ST_REQUEST;
                endcase
            end
            default: n_stage = r_stage;
        endcase
    end

    // Results
    always_comb begin
        first  = make_result(ACT_READ, psz, 1'b1, '0, 1'b0, 1'b0);
        second = make_result(ACT_READ, '0, 1'b0, '0, 1'b0, 1'b0);
        o_seq.any = 1'b1;
        o_seq.two = 1'b0;
        case (i_item.cmd)
            CMD_SETUP: begin
                o_seq.two = 1'b1;
                if (!i_item.handled) begin
                    if (i_item.request_type[4:0] == 5'd2) begin
                        second = make_result(ACT_STALL_EP, '0, 1'b0,
                                             i_item.request_index, 1'b0, 1'b0);
                    end else begin
                        second = make_result(ACT_STALL_BOTH, '0, 1'b0, '0, 1'b0, 1'b0);
                    end
                end else if (!i_item.request_type[7]) begin
                    if (size != '0) begin
                        second = make_result(ACT_READ, size, 1'b1, '0, 1'b0, 1'b0);
                    end else begin
                        second = make_result(ACT_WRITE, '0, 1'b0, '0, 1'b0, 1'b0);
                    end
                end else if (size != '0) begin
                    second = make_result(ACT_WRITE, size, 1'b1, '0, 1'b0, 1'b0);
                end else if (short_whole) begin
                    second = make_result(ACT_WRITE, '0, 1'b0, '0, 1'b0, 1'b0);
                end else begin
                    second = make_result(ACT_READ, '0, 1'b0, '0, 1'b0, 1'b0);
                end
            end
            CMD_IN_DONE: begin
                unique case (r_stage)
                    ST_DATA_IN_ZLP:
                        first = make_result(ACT_WRITE, '0, 1'b0, '0, 1'b0, 1'b0);
                    ST_DATA_IN:
                        first = make_result(ACT_READ, '0, 1'b0, '0, 1'b0, 1'b0);
                    ST_STATUS_IN:
                        first = make_result(ACT_READ, psz, 1'b1, '0, 1'b1, 1'b0);
                    default:
                        first = make_result(ACT_READ, psz, 1'b1, '0, 1'b0, 1'b1);
                endcase
            end
            CMD_OUT_DONE: begin
                unique case (r_stage)
                    ST_DATA_OUT:
                        first = make_result(ACT_WRITE, '0, 1'b0, '0, 1'b0, 1'b0);
                    ST_STATUS_OUT:
                        first = make_result(ACT_READ, psz, 1'b1, '0, 1'b1, 1'b0);
                    default:
                        first = make_result(ACT_READ, psz, 1'b1, '0, 1'b0, 1'b1);
                endcase
            end
            default: o_seq.any = 1'b0;
        endcase
        first.stage  = n_stage;
        second.stage = n_stage;
        first.last   = !o_seq.two;
        second.last  = 1'b1;
        o_seq.first  = first;
        o_seq.second = second;
    end

endmodule

[rtl/usb_control_endpoint_stages.sv]
// USB endpoint-0 control transfer stage sequencer, top level.
// An accepted beat is held in the input register, and its first result is then
// loaded into the output register once that register is empty or draining.
// A transfer-done event yields one result beat and a setup event two, both through
// the single output register; a new event is taken as the held one sends its last.
// Reset (i_rst_n low, synchronous): stage returns to request, buffers empty,
// packet_size_log2 back to 6. Depends on ucep_pkg, ucep_cfg, ucep_seq.
module usb_control_endpoint_stages (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // event input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ucep_pkg::t_in_item  i_in_item,
    // result output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ucep_pkg::t_out_item o_out_item,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ucep_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_second;     // first beat of a setup already sent
    logic       r_out_valid;
    t_out_item  r_out;

    logic [2:0] packet_size_log2;
    t_seq_out   seq;
    logic       out_free;
    logic       emit;
    logic       last_emit;
    logic       drop;
    logic       in_done;
    logic       in_accept;

    ucep_cfg u_cfg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_packet_size_log2 (packet_size_log2)
    );

    // Stage update lands with the last beat of the item
    ucep_seq u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item             (r_in),
        .i_commit           (last_emit),
        .i_packet_size_log2 (packet_size_log2),
        .o_seq              (seq)
    );

    // Output register takes a beat when empty or draining
    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit      = r_in_valid && seq.any && out_free;
    assign last_emit = emit && (r_second || !seq.two);
    // Drop an unknown command without any result
    assign drop      = r_in_valid && !seq.any;
    assign in_done   = last_emit || drop;

    // Hold the input while the held item still has beats to send
    assign o_in_stall = r_in_valid && !in_done;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (in_done) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (last_emit) begin
            r_second <= 1'b0;
        end else if (emit) begin
            r_second <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= r_second ? seq.second : seq.first;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Second beat is only ever pending for a setup event
    a_second_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_in_valid && r_in.cmd == CMD_SETUP))
        else $error("second beat pending without a setup item");

    // A completed request always lands back in the request stage with a read
    a_done_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.request_done) |->
            (r_out.stage == ST_REQUEST && r_out.action == ACT_READ && !r_out.sequence_error))
        else $error("request done outside the request stage");

    // The first beat of a setup is the packet-sized re-arm read
    a_first_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_out.action == ACT_READ && r_out.with_data))
        else $error("non-final beat is not a re-arm read");

    // After the first beat of a setup is sent, the second stays pending behind it
    a_second_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !last_emit) |=> (r_second && r_out_valid && !r_out.last))
        else $error("first setup beat not followed by second");

endmodule

[dv/tb_usb_control_endpoint_stages.sv]
// Testbench for usb_control_endpoint_stages: endpoint-0 control transfer stage sequencing.
// Predicts every action beat from its own stage tracker and checks it at the output.
// Depends on ucep_pkg and the RTL of the block; it needs nothing else.
module tb_usb_control_endpoint_stages;
    import ucep_pkg::*;

    localparam int HalfPeriod    = 6;
    localparam int MaxIdle       = 19;
    localparam int RandomEvents  = 1250;
    localparam int SettleCycles  = 8;
    localparam int TimeoutCycles = 600000;
    localparam int ReportLimit   = 10;
    localparam int InBits        = $bits(t_in_item);

    // cmd value that the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_item;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Stage tracker: our own copy of the sequencer state and its register
    t_stage     ep0_stage    = ST_REQUEST;
    logic [2:0] ep0_pkt_log2 = PacketLog2Reset;

    t_out_item  pending_actions [$];
    int         failures    = 0;
    int         events_sent = 0;
    logic       src_idle    = 1'b1;
    logic       sink_idle   = 1'b1;

    usb_control_endpoint_stages u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(HalfPeriod) clk = ~clk;

    // ------------------------------------------------------------------
    // Stage tracker
    // ------------------------------------------------------------------

    // Max packet size in bytes; out-of-range register values clamp to 8..64
    function automatic logic [15:0] packet_bytes();
        logic [2:0] lg;
        lg = ep0_pkt_log2;
        if (lg < 3'd3) lg = 3'd3;
        if (lg > 3'd6) lg = 3'd6;
        return 16'd1 << lg;
    endfunction

    function automatic t_out_item endpoint_beat(
        input logic [1:0]  act,
        input logic [15:0] len,
        input logic        with_buf,
        input logic [15:0] ep,
        input logic        done,
        input logic        err
    );
        t_out_item b;
        b                = '0;
        b.action         = act;
        b.length         = len;
        b.with_data      = with_buf;
        b.stall_endpoint = ep;
        b.request_done   = done;
        b.sequence_error = err;
        return b;
    endfunction

    // Advance the stage tracker by one accepted event and queue its action beats
    task automatic predict_endpoint_actions(input t_in_item ev);
        t_out_item   beats [2];
        int          n;
        logic [15:0] psz;
        logic [15:0] size;
        psz = packet_bytes();
        n   = 0;
        case (ev.cmd)
            CMD_SETUP: begin
                // Clip the handler's response to wLength; always re-arm the setup read first
                size = (ev.response_size > ev.request_length) ? ev.request_length
                                                               : ev.response_size;
                ep0_stage    = ST_REQUEST;
                n = 2;
                beats[0] = endpoint_beat(ACT_READ, psz, 1'b1, 16'd0, 1'b0, 1'b0);
                if (!ev.handled) begin
                    if (ev.request_type[4:0] == 5'd2) begin
                        beats[1] = endpoint_beat(ACT_STALL_EP, 16'd0, 1'b0, ev.request_index,
                                                 1'b0, 1'b0);
                    end else begin
                        beats[1] = endpoint_beat(ACT_STALL_BOTH, 16'd0, 1'b0, 16'd0,
                                                 1'b0, 1'b0);
                    end
                end else if (!ev.request_type[7]) begin
                    // host-to-device: OUT data stage, or straight to IN status
                    if (size != 16'd0) begin
                        ep0_stage = ST_DATA_OUT;
                        beats[1]  = endpoint_beat(ACT_READ, size, 1'b1, 16'd0, 1'b0, 1'b0);
                    end else begin
                        ep0_stage = ST_STATUS_IN;
                        beats[1]  = endpoint_beat(ACT_WRITE, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0);
                    end
                end else if (size < ev.request_length && (size & (psz - 16'd1)) == 16'd0) begin
                    // short response, whole packets: a ZLP must close the data stage
                    if (size != 16'd0) ep0_stage = ST_DATA_IN_ZLP;
                    else ep0_stage = ST_DATA_IN;
                    beats[1] = endpoint_beat(ACT_WRITE, size, size != 16'd0, 16'd0,
                                             1'b0, 1'b0);
                end else if (size != 16'd0) begin
                    ep0_stage = ST_DATA_IN;
                    beats[1]  = endpoint_beat(ACT_WRITE, size, 1'b1, 16'd0, 1'b0, 1'b0);
                end else begin
                    ep0_stage = ST_STATUS_OUT;
                    beats[1]  = endpoint_beat(ACT_READ, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0);
                end
            end
            CMD_IN_DONE: begin
                n = 1;
                case (ep0_stage)
                    ST_DATA_IN_ZLP: begin
                        ep0_stage = ST_DATA_IN;
                        beats[0]  = endpoint_beat(ACT_WRITE, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0);
                    end
                    ST_DATA_IN: begin
                        ep0_stage = ST_STATUS_OUT;
                        beats[0]  = endpoint_beat(ACT_READ, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0);
                    end
                    ST_STATUS_IN: begin
                        ep0_stage = ST_REQUEST;
                        beats[0]  = endpoint_beat(ACT_READ, psz, 1'b1, 16'd0, 1'b1, 1'b0);
                    end
                    default: begin
                        ep0_stage = ST_REQUEST;
                        beats[0]  = endpoint_beat(ACT_READ, psz, 1'b1, 16'd0, 1'b0, 1'b1);
                    end
                endcase
            end
            CMD_OUT_DONE: begin
                n = 1;
                case (ep0_stage)
                    ST_DATA_OUT: begin
                        ep0_stage = ST_STATUS_IN;
                        beats[0]  = endpoint_beat(ACT_WRITE, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0);
                    end
                    ST_STATUS_OUT: begin
                        ep0_stage = ST_REQUEST;
                        beats[0]  = endpoint_beat(ACT_READ, psz, 1'b1, 16'd0, 1'b1, 1'b0);
                    end
                    default: begin
                        ep0_stage = ST_REQUEST;
                        beats[0]  = endpoint_beat(ACT_READ, psz, 1'b1, 16'd0, 1'b0, 1'b1);
                    end
                endcase
            end
            default: n = 0;   // unknown command: no beat, no state change
        endcase
        for (int i = 0; i < n; i++) begin
            beats[i].stage = ep0_stage;
            beats[i].last  = (i == n - 1);
            pending_actions.push_back(beats[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= ReportLimit) $display("%0t ERROR: %s", $time, msg);
    endtask

    function automatic string describe(input t_out_item b);
        return $sformatf("act=%0d len=%0d data=%0d ep=%0d done=%0d err=%0d stage=%0d last=%0d",
                         b.action, b.length, b.with_data, b.stall_endpoint, b.request_done,
                         b.sequence_error, b.stage, b.last);
    endfunction

    task automatic check_action(input t_out_item got);
        t_out_item want;
        if (pending_actions.size() == 0) begin
            note_failure({"unexpected beat: ", describe(got)});
            return;
        end
        want = pending_actions.pop_front();
        if (got.action !== want.action || got.length !== want.length ||
            got.with_data !== want.with_data || got.stall_endpoint !== want.stall_endpoint ||
            got.request_done !== want.request_done ||
            got.sequence_error !== want.sequence_error ||
            got.stage !== want.stage || got.last !== want.last) begin
            note_failure({"expected ", describe(want), " got ", describe(got)});
        end
    endtask

    // Sample every accepted output beat at the rising edge
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) check_action(out_item);
    end

    // Output side: hold stall for a random number of cycles before each beat
    initial begin : result_sink
        int wait_cycles;
        @(negedge clk);
        forever begin
            wait_cycles = sink_idle ? $urandom_range(0, MaxIdle) : 0;
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one event beat. Enter and leave at a falling edge; valid stays high on
    // return so a back-to-back beat needs no drop.
    task automatic send_event(input t_in_item ev);
        int gap;
        gap = src_idle ? $urandom_range(0, MaxIdle) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= ev;
        do @(posedge clk); while (in_stall);
        predict_endpoint_actions(ev);
        if (ev.cmd != CMD_UNUSED) events_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted beat is back, then let the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_actions.size() != 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    // Write packet_size_log2 with random upper bits, then read it back
    task automatic write_packet_log2(input logic [2:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PACKET_SIZE_LOG2, 2'b00};
        pwdata  <= {($urandom_range(0, 1) != 0) ? 29'($urandom) : 29'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        ep0_pkt_log2 = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[2:0] !== value) begin
            note_failure($sformatf("packet_size_log2 read %0d, wrote %0d", prdata[2:0], value));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Event builders
    // ------------------------------------------------------------------

    function automatic t_in_item setup_event(
        input logic [7:0]  rtype,
        input logic [15:0] wlen,
        input logic [15:0] widx,
        input logic        ok,
        input logic [15:0] rsize
    );
        t_in_item ev;
        ev.cmd            = CMD_SETUP;
        ev.request_type   = rtype;
        ev.request_length = wlen;
        ev.request_index  = widx;
        ev.handled        = ok;
        ev.response_size  = rsize;
        return ev;
    endfunction

    // A non-setup event; the setup fields carry random junk that must not matter
    function automatic t_in_item done_event(input logic [1:0] cmd);
        t_in_item ev;
        ev     = InBits'({$urandom, $urandom});
        ev.cmd = cmd;
        return ev;
    endfunction

    // Lengths biased toward packet boundaries and the extremes
    function automatic logic [15:0] pick_length();
        logic [15:0] psz;
        psz = packet_bytes();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 4 * psz));
            1:       return psz * 16'($urandom_range(0, 8));
            2, 3:    return 16'($urandom);
            4:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: return psz * 16'($urandom_range(1, 4)) - 16'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic t_in_item random_setup();
        t_in_item ev;
        ev.cmd            = CMD_SETUP;
        ev.request_type   = 8'($urandom);
        if ($urandom_range(0, 3) == 0) ev.request_type[4:0] = 5'd2;
        ev.request_length = pick_length();
        ev.request_index  = 16'($urandom);
        ev.handled        = ($urandom_range(0, 7) != 0);
        ev.response_size  = ($urandom_range(0, 2) == 0) ? ev.request_length : pick_length();
        return ev;
    endfunction

    // The done event that the current stage waits for
    function automatic logic [1:0] completion_for_stage(input t_stage s);
        case (s)
            ST_DATA_IN, ST_DATA_IN_ZLP, ST_STATUS_IN: return CMD_IN_DONE;
            default:                                  return CMD_OUT_DONE;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walk every stage path once at the reset packet size (64 bytes)
    task automatic test_directed_stages();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        // done event with nothing open: mismatch
        send_event(done_event(CMD_IN_DONE));
        // OUT data stage, then IN status
        send_event(setup_event(8'h00, 16'd16, 16'h0000, 1'b1, 16'd16));
        send_event(done_event(CMD_OUT_DONE));
        send_event(done_event(CMD_IN_DONE));
        // short IN response of whole packets: data, ZLP, OUT status
        send_event(setup_event(8'h80, 16'd200, 16'h0000, 1'b1, 16'd128));
        send_event(done_event(CMD_IN_DONE));
        send_event(done_event(CMD_IN_DONE));
        send_event(done_event(CMD_OUT_DONE));
        // response clipped to wLength, then an OUT done in the IN data stage
        send_event(setup_event(8'hC0, 16'd16, 16'h0000, 1'b1, 16'hFFFF));
        send_event(done_event(CMD_OUT_DONE));
        // wLength zero on an IN request: straight to OUT status; IN done there is a mismatch
        send_event(setup_event(8'h80, 16'd0, 16'h0000, 1'b1, 16'd5));
        send_event(done_event(CMD_IN_DONE));
        // empty IN response shorter than wLength: a lone ZLP
        send_event(setup_event(8'h80, 16'd8, 16'h0000, 1'b1, 16'd0));
        send_event(done_event(CMD_IN_DONE));
        send_event(done_event(CMD_OUT_DONE));
        // OUT request with no data, then back-to-back unhandled setups
        send_event(setup_event(8'h00, 16'hFFFF, 16'h0000, 1'b1, 16'd0));
        send_event(setup_event(8'h02, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF));
        send_event(setup_event(8'hFD, 16'd0, 16'h1234, 1'b0, 16'd0));
        // unknown command with every bit set: ignored
        send_event('1);
        // largest OUT data stage, interrupted by a setup
        send_event(setup_event(8'h7F, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF));
        send_event(setup_event(8'hFF, 16'hFFFF, 16'h0000, 1'b1, 16'hFFC0));
        send_event(done_event(CMD_OUT_DONE));
        send_event(done_event(CMD_OUT_DONE));
        drain_results();
    endtask

    // Every register value, the out-of-range ones too, through the ZLP decision
    task automatic test_packet_sizes();
        logic [2:0] sizes [8];
        sizes = '{3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd7, 3'd2, 3'd1};
        foreach (sizes[i]) begin
            write_packet_log2(sizes[i]);
            send_event(setup_event(8'h80, 16'hFFFF, 16'h0000, 1'b1, packet_bytes() * 16'd2));
            send_event(done_event(CMD_IN_DONE));
            drain_results();
        end
    endtask

    // One control transfer with random content; now and then break the sequence
    task automatic run_transfer();
        int steps;
        int roll;
        logic [1:0] want;
        if ($urandom_range(0, 14) == 0) send_event(done_event(2'($urandom_range(1, 2))));
        send_event(random_setup());
        steps = 0;
        while (ep0_stage != ST_REQUEST && steps < 4) begin
            want = completion_for_stage(ep0_stage);
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
                send_event(random_setup());
            end else if (roll == 1) begin
                send_event(done_event(CMD_UNUSED));
            end else if (roll == 2) begin
                send_event(done_event((want == CMD_IN_DONE) ? CMD_OUT_DONE : CMD_IN_DONE));
            end else begin
                send_event(done_event(want));
            end
            steps++;
        end
    endtask

    task automatic test_random_transfers();
        int target;
        int block;
        target = events_sent + RandomEvents;
        block  = 0;
        while (events_sent < target) begin
            if (block % 8 == 7) begin
                drain_results();
                write_packet_log2(($urandom_range(0, 3) == 0) ? 3'($urandom)
                                                              : 3'($urandom_range(3, 6)));
            end else if (block % 8 == 3) begin
                // hold the sender until every beat is back
                drain_results();
            end
            case ($urandom_range(0, 3))
                0:       begin src_idle = 1'b1; sink_idle = 1'b1; end
                1:       begin src_idle = 1'b0; sink_idle = 1'b0; end
                2:       begin src_idle = 1'b1; sink_idle = 1'b0; end
                default: begin src_idle = 1'b0; sink_idle = 1'b1; end
            endcase
            repeat (12) run_transfer();
            block++;
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin : run
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_stages();
        test_packet_sizes();
        test_random_transfers();
        if (failures == 0 && pending_actions.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(TimeoutCycles * 2 * HalfPeriod);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/ucep_pkg.sv
rtl/ucep_cfg.sv
rtl/ucep_seq.sv
rtl/usb_control_endpoint_stages.sv
dv/tb_usb_control_endpoint_stages.sv
